// File: rtl/sit_pkg.sv
// Shared types and constants of the sorted insertion table.
`timescale 1ns / 1ps

package sit_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyW        = 16;
  localparam int unsigned TagW        = 16;
  localparam int unsigned EntryW      = KeyW + TagW;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncDrain  = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMITTED  = 2'd2,
    ST_EMPTY    = 2'd3
  } sit_status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic        latch_new;   // capture tag and key of the incoming item
    logic        set_idx_top; // point at the last stored entry, read it
    logic        set_idx_zero;// point at the first entry, read it
    logic        step_down;   // move the read entry one place up, walk down
    logic        put_above;   // write the new entry above the read one
    logic        put_zero;    // write the new entry at place zero
    logic        drn_emit;    // load the read entry into the output register
    logic        resp_load;   // load a status-only result
    sit_status_e resp_code;
  } sit_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic key_gt;
    logic idx_zero;
    logic idx_last;
    logic out_free;
  } sit_stat_t;

endpackage

// File: rtl/sit_ctrl.sv
// Controller state machine of the sorted insertion table.
`timescale 1ns / 1ps

module sit_ctrl import sit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      func_i,
  input  sit_stat_t stat_i,
  output sit_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_DRN  = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  sit_status_e code_q, code_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.resp_code = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_new = 1'b1;
          if (func_i == FuncInsert) begin
            if (stat_i.full) begin
              code_d  = ST_FULL;
              state_d = S_RESP;
            end else if (stat_i.empty) begin
              state_d = S_PUT;
            end else begin
              cmd_o.set_idx_top = 1'b1;
              state_d = S_INS;
            end
          end else begin
            if (stat_i.empty) begin
              code_d  = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              cmd_o.set_idx_zero = 1'b1;
              state_d = S_DRN;
            end
          end
        end
      end
      S_INS: begin
        if (stat_i.key_gt) begin
          cmd_o.step_down = 1'b1;
          if (stat_i.idx_zero) begin
            state_d = S_PUT;
          end
        end else begin
          cmd_o.put_above = 1'b1;
          code_d  = ST_ACCEPTED;
          state_d = S_RESP;
        end
      end
      S_PUT: begin
        cmd_o.put_zero = 1'b1;
        code_d  = ST_ACCEPTED;
        state_d = S_RESP;
      end
      S_DRN: begin
        if (stat_i.out_free) begin
          cmd_o.drn_emit = 1'b1;
          if (stat_i.idx_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_ACCEPTED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

// File: rtl/sit_dpath.sv
// Datapath of the sorted insertion table: entry memory, pointers, output register.
`timescale 1ns / 1ps

module sit_dpath import sit_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TagW-1:0]   tag_i,
  input  logic [KeyW-1:0]   key_i,
  input  sit_cmd_t          cmd_i,
  output sit_stat_t         stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TagW-1:0]   out_tag_o,
  output logic [KeyW-1:0]   out_key_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Capacity);

  // entry memory: {tag, key}, one write and one registered read a cycle
  logic [EntryW-1:0] mem_q [Capacity];
  logic [EntryW-1:0] rdata_q;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  logic [EntryW-1:0] wr_data;
  logic              wr_en;

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [TagW-1:0] new_tag_q;
  logic [KeyW-1:0] new_key_q;
  logic [CntW-1:0] count_m1;
  logic [IdxW-1:0] idx_p1, idx_m1;

  logic            out_valid_q, out_valid_d;
  logic [TagW-1:0] out_tag_q;
  logic [KeyW-1:0] out_key_q;
  logic [1:0]      status_q;
  logic            last_q;
  logic            load;

  assign count_m1 = count_q - CntW'(1);
  assign idx_p1   = idx_q + IdxW'(1);
  assign idx_m1   = idx_q - IdxW'(1);

  always_comb begin
    if (cmd_i.set_idx_top) begin
      rd_addr = count_m1[IdxW-1:0];
    end else if (cmd_i.set_idx_zero) begin
      rd_addr = '0;
    end else if (cmd_i.step_down) begin
      rd_addr = idx_m1;
    end else if (cmd_i.drn_emit) begin
      rd_addr = idx_p1;
    end else begin
      rd_addr = idx_q;
    end
  end

  assign wr_en   = cmd_i.step_down | cmd_i.put_above | cmd_i.put_zero;
  assign wr_addr = cmd_i.put_zero ? '0 : idx_p1;
  assign wr_data = cmd_i.step_down ? rdata_q : {new_tag_q, new_key_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.set_idx_top) begin
      idx_d = count_m1[IdxW-1:0];
    end else if (cmd_i.set_idx_zero) begin
      idx_d = '0;
    end else if (cmd_i.step_down) begin
      idx_d = idx_m1;
    end else if (cmd_i.drn_emit) begin
      idx_d = idx_p1;
    end
  end

  assign count_d = (cmd_i.put_above | cmd_i.put_zero) ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_new) begin
      new_tag_q <= tag_i;
      new_key_q <= key_i;
    end
  end

  // output register
  assign load        = cmd_i.drn_emit | cmd_i.resp_load;
  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drn_emit) begin
      out_tag_q <= rdata_q[EntryW-1:KeyW];
      out_key_q <= rdata_q[KeyW-1:0];
      status_q  <= ST_EMITTED;
      last_q    <= stat_o.idx_last;
    end else if (cmd_i.resp_load) begin
      out_tag_q <= '0;
      out_key_q <= '0;
      status_q  <= cmd_i.resp_code;
      last_q    <= 1'b1;
    end
  end

  assign stat_o.full     = (count_q == CntFull);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.key_gt   = (rdata_q[KeyW-1:0] > new_key_q);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.idx_last = (CntW'(idx_q) == count_m1);
  assign stat_o.out_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_tag_o   = out_tag_q;
  assign out_key_o   = out_key_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// File: rtl/sorted_insertion_table.sv
// Top level of the sorted insertion table: controller plus datapath.
`timescale 1ns / 1ps

// Channel | Handshake                | Payload
// --------+--------------------------+-----------------------------------
// in      | in_valid_i / in_stall_o  | func_i, tag_i, key_i
// out     | out_valid_o / out_stall_i| out_tag_o, out_key_o, status_o, last_o
//
// Entries live in a single-port-write, registered-read memory kept in
// ascending key order. An insert walks down from the last entry, one memory
// read and one write per cycle, moving each larger entry up one place, and
// writes the new entry above the first entry whose key is not greater, or
// at place zero if there is none. An insert into a full table and a drain
// of an empty table give a status-only result. A drain emits the entries
// from place zero up, one entry per cycle while the output is not stalled.
// The controller waits while a stalled result holds the output register.
// Reset clears count, index and out_valid; the memory needs no clearing.
// A result waiting in the output register under stall does not block the
// next transaction from being taken; the block stalls input while busy.

module sorted_insertion_table import sit_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            func_i,
  input  logic [TagW-1:0] tag_i,
  input  logic [KeyW-1:0] key_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [TagW-1:0] out_tag_o,
  output logic [KeyW-1:0] out_key_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  sit_cmd_t  cmd;
  sit_stat_t stat;

  // sequence inserts and drains
  sit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // hold entries, pointers and the output register
  sit_dpath #(
    .Capacity (Capacity)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_i),
    .key_i       (key_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tag_o   (out_tag_o),
    .out_key_o   (out_key_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
